FILE: rtl/hlm_pkg.sv
`default_nettype none

package hlm_pkg;

   localparam int SLOTS  = 6;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   // Slots that have a configured id byte; later slots read id zero
   localparam int ID_SLOTS = 6;
   localparam int ID_W     = 8 * ID_SLOTS;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ACK    = 2'd1;
   localparam logic [1:0] OP_REPORT = 2'd2;

   localparam logic [1:0] CSR_INTERVAL   = 2'd0;
   localparam logic [1:0] CSR_MISS_LIMIT = 2'd1;
   localparam logic [1:0] CSR_SLOT_IDS   = 2'd2;

   localparam logic [15:0] INTERVAL_RESET   = 16'd1000;
   localparam logic [7:0]  MISS_LIMIT_RESET = 8'd5;
   localparam logic [15:0] TICK_MAX         = 16'hFFFF;
   localparam logic [7:0]  MISS_MAX         = 8'hFF;

   typedef enum logic [1:0] {
      LINK_UNKNOWN = 2'd0,
      LINK_ONLINE  = 2'd1,
      LINK_OFFLINE = 2'd2
   } link_type;

   typedef enum logic [1:0] {
      EV_PROBE    = 2'd0,
      EV_INSERTED = 2'd1,
      EV_REMOVED  = 2'd2,
      EV_FLUSH    = 2'd3
   } evkind_type;

   typedef struct packed {
      link_type    status;
      logic [7:0]  miss;
      logic [7:0]  mtype;
      logic [7:0]  msub;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_WALK,
      S_REMOVE,
      S_PROBE,
      S_FLUSH,
      S_INSERT,
      S_REPORT
   } fsm_type;

   function automatic logic [7:0] slot_id(input logic [ID_W-1:0] ids, input logic [2:0] idx);
      logic [ID_W-1:0] shifted;
      shifted = ids >> {idx, 3'b000};
      if (32'(idx) >= ID_SLOTS) begin
         return 8'd0;
      end
      return shifted[7:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/hlm_ram.sv
`default_nettype none

module hlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/heartbeat_liveness_monitor.sv
// Sequence: a tick that starts no round and an unused operation finish in idle; a matching
// acknowledge passes read and update, then insert if the slot was not online; a report passes
// read, update and report per slot; a heartbeat round passes read, update and probe per slot,
// plus remove per removal and flush for the flush request. One request at a time; the slot
// memory walk (read, modify, write back, one slot after another through a RAM whose read and
// write ports share one slot address) sets the pace. Reset: synchronous, active high; registers
// return to defaults at once; per-slot valid bits make every slot read as zero until written.
`default_nettype none

module heartbeat_liveness_monitor (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_ack_module_id,
   input  wire logic [7:0]  req_ack_type,
   input  wire logic [7:0]  req_ack_subtype,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_kind,
   output logic [2:0]       rsp_slot_index,
   output logic [7:0]       rsp_event_module_id,
   output logic [7:0]       rsp_event_type,
   output logic [7:0]       rsp_event_subtype,
   output logic             rsp_last,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [hlm_pkg::ID_W-1:0] csr_wdata
);

   import hlm_pkg::*;

   // ---------------------------------------------------------------- registers
   fsm_type            state_ff, state_in;

   logic [15:0]        interval_ff;
   logic [7:0]         miss_limit_ff;
   logic [ID_W-1:0]    slot_ids_ff;

   logic [15:0]        tick_ff;
   logic [SLOT_W-1:0]  flush_ptr_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [1:0]         op_ff;
   logic [7:0]         ack_type_ff;
   logic [7:0]         ack_sub_ff;
   logic [SLOTS-1:0]   valid_ff;

   // Working copy of the slot between its write-back and its events
   logic [7:0]         old_type_ff, old_sub_ff;
   logic [7:0]         new_type_ff, new_sub_ff;
   logic               old_online_ff;

   // Flush candidate, captured as the walk passes its slot
   logic               flush_need_ff;
   logic [7:0]         flush_type_ff, flush_sub_ff;

   logic               rsp_valid_ff;
   evkind_type         rsp_kind_ff;
   logic [2:0]         rsp_slot_ff;
   logic [7:0]         rsp_id_ff, rsp_type_ff, rsp_sub_ff;
   logic               rsp_last_ff;

   // ---------------------------------------------------------------- request side
   logic               req_fire;
   logic [15:0]        tick_sat;
   logic               round_due;
   logic [SLOT_W-1:0]  flush_ptr_next;
   logic               ack_hit;
   logic [SLOT_W-1:0]  ack_slot;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign tick_sat  = (tick_ff != TICK_MAX) ? tick_ff + 16'd1 : tick_ff;
   assign round_due = (tick_sat >= interval_ff);

   // Advance the round-robin flush pointer, wrapping at the last slot
   assign flush_ptr_next = (flush_ptr_ff >= LAST_SLOT) ? '0 : flush_ptr_ff + SLOT_W'(1);

   // Lowest slot whose configured id matches wins
   always_comb begin
      ack_hit  = 1'b0;
      ack_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_id(slot_ids_ff, 3'(i)) == req_ack_module_id) begin
            ack_hit  = 1'b1;
            ack_slot = SLOT_W'(i);
         end
      end
   end

   // ---------------------------------------------------------------- slot memory
   logic                ram_wr_en, ram_rd_en;
   logic [ENTRY_W-1:0]  ram_rd_data;
   slot_entry_type      cur_entry, tick_entry, new_entry;
   logic [7:0]          miss_up;
   logic                remove_now;

   hlm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (new_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // A slot never written reads as its reset value of all zeros. Only one slot is in
   // flight at a time, so the read-modify-write needs no forwarding.
   assign cur_entry = valid_ff[slot_ff] ? slot_entry_type'(ram_rd_data) : '0;

   // Heartbeat update: count a miss against an outstanding probe (saturating), drop the slot
   // offline at the limit, mark a fresh probe outstanding; an acknowledge sets it online instead.
   always_comb begin
      miss_up    = (cur_entry.miss != MISS_MAX) ? cur_entry.miss + 8'd1 : cur_entry.miss;
      remove_now = (cur_entry.miss != 8'd0) && (miss_up >= miss_limit_ff)
                   && (cur_entry.status != LINK_OFFLINE);
      tick_entry        = cur_entry;
      tick_entry.miss   = (cur_entry.miss == 8'd0) ? 8'd1 : miss_up;
      if (remove_now) begin
         tick_entry.status = LINK_OFFLINE;
         tick_entry.mtype  = 8'd0;
         tick_entry.msub   = 8'd0;
      end
      if (op_ff == OP_ACK) begin
         new_entry.status = LINK_ONLINE;
         new_entry.miss   = 8'd0;
         new_entry.mtype  = ack_type_ff;
         new_entry.msub   = ack_sub_ff;
      end else begin
         new_entry = tick_entry;
      end
   end

   // ---------------------------------------------------------------- sequencer
   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_operation)
                  OP_TICK:   state_in = round_due ? S_READ : S_IDLE;
                  OP_ACK:    state_in = ack_hit ? S_READ : S_IDLE;
                  OP_REPORT: state_in = S_READ;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_READ:   state_in = S_WALK;
         S_WALK: begin
            unique case (op_ff)
               OP_TICK: state_in = remove_now ? S_REMOVE : S_PROBE;
               OP_ACK:  state_in = (cur_entry.status != LINK_ONLINE) ? S_INSERT : S_IDLE;
               default: state_in = S_REPORT;
            endcase
         end
         S_REMOVE: if (out_free) state_in = S_PROBE;
         S_PROBE: begin
            if (out_free) begin
               if (slot_ff != LAST_SLOT) begin
                  state_in = S_READ;
               end else begin
                  state_in = flush_need_ff ? S_FLUSH : S_IDLE;
               end
            end
         end
         S_FLUSH:  if (out_free) state_in = S_IDLE;
         S_INSERT: if (out_free) state_in = S_IDLE;
         S_REPORT: begin
            if (out_free) begin
               state_in = (slot_ff != LAST_SLOT) ? S_READ : S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   logic               emit;
   evkind_type         emit_kind;
   logic [SLOT_W-1:0]  emit_slot;
   logic [7:0]         emit_type, emit_sub;
   logic               emit_last;
   logic               slot_advance;

   always_comb begin
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      emit         = 1'b0;
      emit_kind    = EV_PROBE;
      emit_slot    = slot_ff;
      emit_type    = new_type_ff;
      emit_sub     = new_sub_ff;
      emit_last    = 1'b0;
      slot_advance = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_READ: ram_rd_en = 1'b1;
         S_WALK: ram_wr_en = (op_ff != OP_REPORT);
         S_REMOVE: begin
            // Removal reports the type held before the slot was cleared
            emit      = 1'b1;
            emit_kind = EV_REMOVED;
            emit_type = old_type_ff;
            emit_sub  = old_sub_ff;
         end
         S_PROBE: begin
            emit         = 1'b1;
            emit_kind    = EV_PROBE;
            emit_last    = (slot_ff == LAST_SLOT) && !flush_need_ff;
            slot_advance = out_free && (slot_ff != LAST_SLOT);
         end
         S_FLUSH: begin
            emit      = 1'b1;
            emit_kind = EV_FLUSH;
            emit_slot = flush_ptr_ff;
            emit_type = flush_type_ff;
            emit_sub  = flush_sub_ff;
            emit_last = 1'b1;
         end
         S_INSERT: begin
            emit      = 1'b1;
            emit_kind = EV_INSERTED;
            emit_last = 1'b1;
         end
         S_REPORT: begin
            // Anything not online, unknown included, reports as removed
            emit         = 1'b1;
            emit_kind    = old_online_ff ? EV_INSERTED : EV_REMOVED;
            emit_type    = old_type_ff;
            emit_sub     = old_sub_ff;
            emit_last    = (slot_ff == LAST_SLOT);
            slot_advance = out_free && (slot_ff != LAST_SLOT);
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- state update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         interval_ff   <= INTERVAL_RESET;
         miss_limit_ff <= MISS_LIMIT_RESET;
         slot_ids_ff   <= '0;
         tick_ff       <= '0;
         flush_ptr_ff  <= '0;
         slot_ff       <= '0;
         op_ff         <= OP_TICK;
         valid_ff      <= '0;
         flush_need_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_INTERVAL:   interval_ff   <= csr_wdata[15:0];
               CSR_MISS_LIMIT: miss_limit_ff <= csr_wdata[7:0];
               CSR_SLOT_IDS:   slot_ids_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (req_fire) begin
            op_ff <= req_operation;
            unique case (req_operation)
               OP_TICK: begin
                  tick_ff <= round_due ? '0 : tick_sat;
                  if (round_due) begin
                     slot_ff       <= '0;
                     flush_ptr_ff  <= flush_ptr_next;
                     flush_need_ff <= 1'b0;
                  end
               end
               OP_ACK: begin
                  slot_ff     <= ack_slot;
                  ack_type_ff <= req_ack_type;
                  ack_sub_ff  <= req_ack_subtype;
               end
               OP_REPORT: slot_ff <= '0;
               default: begin
               end
            endcase
         end

         if (state_ff == S_WALK) begin
            old_type_ff   <= cur_entry.mtype;
            old_sub_ff    <= cur_entry.msub;
            new_type_ff   <= new_entry.mtype;
            new_sub_ff    <= new_entry.msub;
            old_online_ff <= (cur_entry.status == LINK_ONLINE);
            if (ram_wr_en) begin
               valid_ff[slot_ff] <= 1'b1;
            end
            // Hold what the flush slot looks like once the walk has passed it
            if ((op_ff == OP_TICK) && (slot_ff == flush_ptr_ff)) begin
               flush_need_ff <= (new_entry.status != LINK_ONLINE);
               flush_type_ff <= new_entry.mtype;
               flush_sub_ff  <= new_entry.msub;
            end
         end

         if (slot_advance) begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end

         if (out_free) begin
            rsp_valid_ff <= emit;
            if (emit) begin
               rsp_kind_ff <= emit_kind;
               rsp_slot_ff <= 3'(emit_slot);
               rsp_id_ff   <= slot_id(slot_ids_ff, 3'(emit_slot));
               rsp_type_ff <= emit_type;
               rsp_sub_ff  <= emit_sub;
               rsp_last_ff <= emit_last;
            end
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = rsp_kind_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_event_module_id = rsp_id_ff;
   assign rsp_event_type      = rsp_type_ff;
   assign rsp_event_subtype   = rsp_sub_ff;
   assign rsp_last            = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   a_write_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_WALK))
      else $error("slot memory written outside the update step");

   a_read_then_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_WALK))
      else $error("slot read not followed by its update step");

   a_removal_not_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_REMOVE) && out_free) |=> (rsp_valid && !rsp_last))
      else $error("removed event closed a round");

   a_flush_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EV_FLUSH)) |-> rsp_last)
      else $error("flush request not marked last");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (slot_ff <= LAST_SLOT) && (flush_ptr_ff <= LAST_SLOT))
      else $error("slot pointer beyond the last slot");

endmodule

`default_nettype wire
